// ===== rtl/core/smcln_pkg.sv =====
// Shared types and constants for the symbol matrix chain log-norm block.
// Used by every module of the block except smcln_ram; depends on nothing.
package smcln_pkg;

  localparam int MaxDim   = 16;
  localparam int DimW     = $clog2(MaxDim);
  localparam int StoreDep = 2 * MaxDim * MaxDim;
  localparam int AddrW    = $clog2(StoreDep);
  localparam int SizeW    = 5;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharOne  = 8'h31;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatBadSym = 2'd1;
  localparam logic [1:0] StatNorm   = 2'd2;

  localparam logic [25:0] Ln2Q26 = 26'd46516320;

  typedef struct packed {
    logic               mode;
    logic               matrix_index;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] entry_value;
    logic [7:0]         symbol_char;
    logic               last;
  } smcln_in_t;

  typedef struct packed {
    logic signed [47:0] log_entrywise_norm;
    logic [1:0]         status;
  } smcln_out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MAC, S_DRAIN, S_MCHK, S_NORM, S_QPASS, S_QDRAIN, S_SQI, S_SQRT,
    S_DIVI, S_DIVS, S_DIVW, S_LOGI, S_LOGN, S_LOGIT, S_LNA, S_LNB, S_ACC,
    S_CHKL, S_SUM, S_SUMCHK, S_EMIT
  } smcln_state_t;

  typedef struct packed {
    logic            restart;
    logic            load_wr;
    logic            latch;
    logic            set_err1;
    logic            set_err2;
    logic            mac_issue;
    logic [DimW-1:0] row;
    logic [DimW-1:0] col;
    logic            mac_first;
    logic            mac_endr;
    logic            norm_init;
    logic            norm_step;
    logic            q_issue;
    logic [DimW-1:0] idx;
    logic            sqrt_init;
    logic            sqrt_step;
    logic            div_init;
    logic            div_step;
    logic            div_wr;
    logic            log_init;
    logic            log_src;
    logic            log_nstep;
    logic            log_istep;
    logic            ln_a;
    logic            ln_b;
    logic            acc_add;
    logic            fin_set;
    logic            sum_clr;
    logic            sum_step;
    logic            emit;
  } smcln_cmd_t;

  typedef struct packed {
    logic err_nz;
    logic m_zero;
    logic norm_done;
    logic logn_done;
    logic sum_pos;
  } smcln_stat_t;

endpackage

// ===== rtl/core/smcln_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Stands alone; no package needed.
module smcln_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/smcln_ctrl.sv =====
// Sequencer of the log-norm block: state machine, loop counters, size register
// and the result valid flag. Depends on smcln_pkg.
module smcln_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  smcln_pkg::smcln_in_t    in_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [4:0]              cfg_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  smcln_pkg::smcln_stat_t  st,
  output smcln_pkg::smcln_cmd_t   cmd
);
  import smcln_pkg::*;

  smcln_state_t    state_r, state_nxt;
  logic [DimW-1:0] idx_r, idx_nxt, col_r, col_nxt, n_m1;
  logic [4:0]      it_r, it_nxt;
  logic            last_r, last_nxt, fin_r, fin_nxt, ovld_r, ovld_nxt;
  logic [SizeW-1:0] size_r, size_nxt;

  assign cfg_ready = 1'b1;
  assign out_valid = ovld_r;

  // Size zero acts as one, anything above the store dimension as the maximum.
  always_comb begin
    if (size_r == '0) begin
      n_m1 = '0;
    end else if (size_r > SizeW'(MaxDim)) begin
      n_m1 = DimW'(MaxDim - 1);
    end else begin
      n_m1 = DimW'(size_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      col_r   <= '0;
      it_r    <= '0;
      last_r  <= 1'b0;
      fin_r   <= 1'b0;
      ovld_r  <= 1'b0;
      size_r  <= SizeW'(MaxDim);
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      col_r   <= col_nxt;
      it_r    <= it_nxt;
      last_r  <= last_nxt;
      fin_r   <= fin_nxt;
      ovld_r  <= ovld_nxt;
      size_r  <= size_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    col_nxt   = col_r;
    it_nxt    = it_r;
    last_nxt  = last_r;
    fin_nxt   = fin_r;
    size_nxt  = size_r;
    ovld_nxt  = ovld_r && !out_ready;
    in_ready  = 1'b0;
    cmd           = '0;
    cmd.row       = idx_r;
    cmd.col       = col_r;
    cmd.idx       = idx_r;
    cmd.log_src   = fin_r;
    cmd.mac_first = (col_r == '0);
    cmd.mac_endr  = (col_r == n_m1);

    if (cfg_valid) begin
      size_nxt    = cfg_data;
      cmd.restart = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_data.mode) begin
            cmd.load_wr = 1'b1;
          end else begin
            last_nxt  = in_data.last;
            state_nxt = S_CHKL;
            if (!st.err_nz) begin
              if (in_data.symbol_char == CharZero || in_data.symbol_char == CharOne) begin
                cmd.latch = 1'b1;
                idx_nxt   = '0;
                col_nxt   = '0;
                state_nxt = S_MAC;
              end else begin
                cmd.set_err1 = 1'b1;
              end
            end
          end
        end
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (col_r == n_m1) begin
          col_nxt = '0;
          if (idx_r == n_m1) begin
            it_nxt    = '0;
            state_nxt = S_DRAIN;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      S_DRAIN: begin
        it_nxt = it_r + 1'b1;
        if (it_r == 5'd1) begin
          state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        if (st.m_zero) begin
          cmd.set_err2 = 1'b1;
          state_nxt    = S_CHKL;
        end else begin
          cmd.norm_init = 1'b1;
          state_nxt     = S_NORM;
        end
      end
      S_NORM: begin
        if (st.norm_done) begin
          idx_nxt   = '0;
          state_nxt = S_QPASS;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_QPASS: begin
        cmd.q_issue = 1'b1;
        if (idx_r == n_m1) begin
          state_nxt = S_QDRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_QDRAIN: state_nxt = S_SQI;
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        it_nxt        = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        it_nxt        = it_r + 1'b1;
        if (it_r == 5'd31) begin
          idx_nxt   = '0;
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        it_nxt       = '0;
        state_nxt    = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_step = 1'b1;
        it_nxt       = it_r + 1'b1;
        if (it_r == 5'd29) begin
          state_nxt = S_DIVW;
        end
      end
      S_DIVW: begin
        cmd.div_wr = 1'b1;
        if (idx_r == n_m1) begin
          state_nxt = S_LOGI;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_DIVI;
        end
      end
      S_LOGI: begin
        cmd.log_init = 1'b1;
        state_nxt    = S_LOGN;
      end
      S_LOGN: begin
        if (st.logn_done) begin
          it_nxt    = '0;
          state_nxt = S_LOGIT;
        end else begin
          cmd.log_nstep = 1'b1;
        end
      end
      S_LOGIT: begin
        cmd.log_istep = 1'b1;
        it_nxt        = it_r + 1'b1;
        if (it_r == 5'd29) begin
          state_nxt = S_LNA;
        end
      end
      S_LNA: begin
        cmd.ln_a  = 1'b1;
        state_nxt = S_LNB;
      end
      S_LNB: begin
        cmd.ln_b  = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (fin_r) begin
          cmd.fin_set = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          cmd.acc_add = 1'b1;
          state_nxt   = S_CHKL;
        end
      end
      S_CHKL: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (st.err_nz) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.sum_clr = 1'b1;
          idx_nxt     = '0;
          state_nxt   = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (idx_r == n_m1) begin
          state_nxt = S_SUMCHK;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SUMCHK: begin
        if (!st.sum_pos) begin
          cmd.set_err2 = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          fin_nxt   = 1'b1;
          state_nxt = S_LOGI;
        end
      end
      S_EMIT: begin
        // The result register is reloaded only once the previous beat is gone.
        if (!ovld_r || out_ready) begin
          cmd.emit    = 1'b1;
          cmd.restart = 1'b1;
          ovld_nxt    = 1'b1;
          fin_nxt     = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/smcln_dp.sv =====
// Datapath of the log-norm block: matrix store, MAC pipeline, normalizer,
// square root, divider, log unit and accumulators. Depends on smcln_pkg, smcln_ram.
module smcln_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  smcln_pkg::smcln_in_t   in_data,
  input  smcln_pkg::smcln_cmd_t  cmd,
  output smcln_pkg::smcln_stat_t st,
  output smcln_pkg::smcln_out_t  out_data
);
  import smcln_pkg::*;

  localparam logic signed [31:0] QOne = 32'sh4000_0000;

  // Matrix store and MAC pipeline.
  logic               sel_r;
  logic [31:0]        rdata;
  logic               v1_r, v2_r, first1_r, first2_r, endr1_r, endr2_r;
  logic [DimW-1:0]    row1_r, row2_r, col1_r;
  logic signed [63:0] prod_r;
  logic signed [51:0] acc_r, acc_nxt, term;
  logic [63:0]        pmag64;
  logic [47:0]        tmag;
  logic signed [51:0] p_r [MaxDim];
  logic [50:0]        m_r, acc_mag;

  // Normalizer and block-scaled vector.
  logic [50:0]        mm_r, pm, pm_sh;
  logic signed [6:0]  e_r;
  logic [4:0]         shamt;
  logic [27:0]        qmag_r [MaxDim];
  logic               qneg_r [MaxDim];
  logic [27:0]        qm;
  logic [55:0]        sq_r;
  logic               sqv_r;
  logic [59:0]        s_r;

  // Square root.
  logic [63:0]        sq_rem_r, sq_res_r, sq_bit_r, sq_try;
  logic [31:0]        r;

  // Divider.
  logic [30:0]        drem_r;
  logic [31:0]        drem2;
  logic [29:0]        quo_r;
  logic               qint_r, dneg_r;
  logic [30:0]        vmag;

  logic signed [31:0] cv_r [MaxDim];
  logic [DimW-1:0]    cv_idx;
  logic signed [31:0] cv_rd;
  logic signed [35:0] sum_r;

  // Log unit.
  logic [35:0]        ly_r;
  logic signed [6:0]  lk_r;
  logic [29:0]        lfrac_r;
  logic [61:0]        ysq;
  logic [31:0]        yt;
  logic signed [7:0]  kk;
  logic signed [39:0] lval;
  logic [36:0]        lmag_r;
  logic               lneg_r;
  logic [62:0]        lnprod;
  logic [30:0]        lnres;
  logic signed [47:0] lnv_r;

  logic signed [47:0] lacc_r, res_r, sat_out;
  logic signed [48:0] sum49;
  logic [1:0]         err_r;

  smcln_ram #(.Width(32), .Depth(StoreDep)) u_ram (
    .clk   (clk),
    .we    (cmd.load_wr),
    .waddr ({in_data.matrix_index, in_data.row_index, in_data.col_index}),
    .wdata (in_data.entry_value),
    .raddr ({sel_r, cmd.row, cmd.col}),
    .rdata (rdata)
  );

  assign cv_idx = v1_r ? col1_r : cmd.idx;
  assign cv_rd  = cv_r[cv_idx];

  // Each product is truncated toward zero to 2^-30 units before summing.
  always_comb begin
    pmag64  = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
    tmag    = pmag64[63:16];
    term    = prod_r[63] ? -$signed({4'b0, tmag}) : $signed({4'b0, tmag});
    acc_nxt = (first2_r ? 52'sd0 : acc_r) + term;
    acc_mag = acc_nxt[51] ? 51'(-acc_nxt) : 51'(acc_nxt);
  end

  always_comb begin
    pm    = p_r[cmd.idx][51] ? 51'(-p_r[cmd.idx]) : 51'(p_r[cmd.idx]);
    shamt = e_r[6] ? 5'(-e_r) : 5'(e_r);
    pm_sh = e_r[6] ? (pm << shamt) : (pm >> shamt);
    qm    = pm_sh[27:0];
  end

  assign r      = sq_res_r[31:0];
  assign sq_try = sq_res_r + sq_bit_r;
  assign drem2  = {drem_r, 1'b0};
  assign vmag   = {qint_r, quo_r};

  always_comb begin
    ysq = ly_r[30:0] * ly_r[30:0];
    yt  = ysq[61:30];
    kk  = 8'(lk_r) - 8'sd30 + (cmd.log_src ? 8'sd0 : 8'(e_r));
    lval = $signed({kk, 30'b0}) + $signed({10'b0, lfrac_r});
    lnprod = lmag_r * Ln2Q26 + 63'h8000_0000;
    lnres  = lnprod[62:32];
    sum49  = {lacc_r[47], lacc_r} + {lnv_r[47], lnv_r};
    if (sum49[48] != sum49[47]) begin
      sat_out = sum49[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end else begin
      sat_out = sum49[47:0];
    end
  end

  assign st.err_nz    = (err_r != StatOk);
  assign st.m_zero    = (m_r == '0);
  assign st.norm_done = (mm_r[50:28] == '0) && mm_r[27];
  assign st.logn_done = (ly_r[35:31] == '0) && ly_r[30];
  assign st.sum_pos   = !sum_r[35] && (sum_r != '0);

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sel_r <= in_data.symbol_char[0];
    end
    row1_r   <= cmd.row;
    col1_r   <= cmd.col;
    first1_r <= cmd.mac_first;
    endr1_r  <= cmd.mac_endr;
    row2_r   <= row1_r;
    first2_r <= first1_r;
    endr2_r  <= endr1_r;
    prod_r   <= $signed(rdata) * cv_rd;
    if (v2_r) begin
      acc_r <= acc_nxt;
      if (endr2_r) begin
        p_r[row2_r] <= acc_nxt;
      end
    end
    if (cmd.norm_init) begin
      mm_r <= m_r;
      e_r  <= '0;
    end else if (cmd.norm_step) begin
      if (mm_r[50:28] != '0) begin
        mm_r <= mm_r >> 1;
        e_r  <= e_r + 7'sd1;
      end else begin
        mm_r <= mm_r << 1;
        e_r  <= e_r - 7'sd1;
      end
    end
    if (cmd.q_issue) begin
      qmag_r[cmd.idx] <= qm;
      qneg_r[cmd.idx] <= p_r[cmd.idx][51];
    end
    sq_r <= qm * qm;
    if (cmd.norm_init) begin
      s_r <= '0;
    end else if (sqv_r) begin
      s_r <= s_r + 60'(sq_r);
    end
    if (cmd.sqrt_init) begin
      sq_rem_r <= 64'(s_r);
      sq_res_r <= '0;
      sq_bit_r <= 64'h4000_0000_0000_0000;
    end else if (cmd.sqrt_step) begin
      if (sq_rem_r >= sq_try) begin
        sq_rem_r <= sq_rem_r - sq_try;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
    // The scaled element never exceeds the norm, so the integer digit is 0 or 1.
    if (cmd.div_init) begin
      dneg_r <= qneg_r[cmd.idx];
      quo_r  <= '0;
      if (32'(qmag_r[cmd.idx]) >= r) begin
        qint_r <= 1'b1;
        drem_r <= 31'(32'(qmag_r[cmd.idx]) - r);
      end else begin
        qint_r <= 1'b0;
        drem_r <= 31'(qmag_r[cmd.idx]);
      end
    end else if (cmd.div_step) begin
      if (drem2 >= r) begin
        drem_r <= 31'(drem2 - r);
        quo_r  <= {quo_r[28:0], 1'b1};
      end else begin
        drem_r <= drem2[30:0];
        quo_r  <= {quo_r[28:0], 1'b0};
      end
    end
    if (cmd.sum_clr) begin
      sum_r <= '0;
    end else if (cmd.sum_step) begin
      sum_r <= sum_r + 36'(cv_rd);
    end
    if (cmd.log_init) begin
      ly_r    <= cmd.log_src ? 36'(sum_r) : 36'(r);
      lk_r    <= 7'sd30;
      lfrac_r <= '0;
    end else if (cmd.log_nstep) begin
      if (ly_r[35:31] != '0) begin
        ly_r <= ly_r >> 1;
        lk_r <= lk_r + 7'sd1;
      end else begin
        ly_r <= ly_r << 1;
        lk_r <= lk_r - 7'sd1;
      end
    end else if (cmd.log_istep) begin
      lfrac_r <= {lfrac_r[28:0], yt[31]};
      ly_r    <= yt[31] ? 36'(yt >> 1) : 36'(yt);
    end
    if (cmd.ln_a) begin
      lneg_r <= lval[39];
      lmag_r <= lval[39] ? 37'(-lval) : 37'(lval);
    end
    if (cmd.ln_b) begin
      lnv_r <= lneg_r ? -$signed(48'(lnres)) : $signed(48'(lnres));
    end
    if (cmd.fin_set) begin
      res_r <= sat_out;
    end
  end

  // Control and sequence state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      sqv_r    <= 1'b0;
      m_r      <= '0;
      err_r    <= StatOk;
      lacc_r   <= '0;
      out_data <= '0;
      for (int i = 0; i < MaxDim; i++) begin
        cv_r[i] <= QOne;
      end
    end else begin
      v1_r  <= cmd.mac_issue;
      v2_r  <= v1_r;
      sqv_r <= cmd.q_issue;
      if (cmd.latch) begin
        m_r <= '0;
      end else if (v2_r && endr2_r && acc_mag > m_r) begin
        m_r <= acc_mag;
      end
      if (cmd.div_wr) begin
        cv_r[cmd.idx] <= dneg_r ? -$signed(32'(vmag)) : $signed(32'(vmag));
      end
      if (cmd.acc_add) begin
        lacc_r <= sat_out;
      end
      if (cmd.set_err1) begin
        err_r <= StatBadSym;
      end else if (cmd.set_err2) begin
        err_r <= StatNorm;
      end
      if (cmd.emit) begin
        out_data.status             <= err_r;
        out_data.log_entrywise_norm <= (err_r == StatOk) ? res_r : '0;
      end
      if (cmd.restart) begin
        err_r  <= StatOk;
        lacc_r <= '0;
        for (int i = 0; i < MaxDim; i++) begin
          cv_r[i] <= QOne;
        end
      end
    end
  end

endmodule

// ===== rtl/core/symbol_matrix_chain_log_norm.sv =====
// Symbol-driven matrix chain: each '0'/'1' symbol multiplies the kept vector by
// one of two stored Q16.16 matrices, renormalizes it and accumulates ln(norm) in
// Q24.24; the symbol flagged last yields one result beat. A symbol, while no
// error is set, runs one MAC per cycle over the matrix store's read port,
// normalizing shifts and one pass over the products for the block scaling, a
// square root, a radix-2 divider per element and a squaring log2 unit. The
// last symbol adds the sum of the vector's elements and its log. A new item is
// taken while an earlier result beat still waits.
// Depends on smcln_pkg, smcln_ctrl, smcln_dp.
module symbol_matrix_chain_log_norm (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  smcln_pkg::smcln_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output smcln_pkg::smcln_out_t  out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [4:0]             cfg_data
);
  import smcln_pkg::*;

  smcln_cmd_t  cmd;
  smcln_stat_t st;

  smcln_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  smcln_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/smcln_chk.sv =====
// Port-level checks for the log-norm block, bound to the top level.
// Depends on smcln_pkg.
module smcln_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input smcln_pkg::smcln_in_t  in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input smcln_pkg::smcln_out_t out_data,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [4:0]            cfg_data
);
  import smcln_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != StatOk |-> out_data.log_entrywise_norm == '0)
    else $error("error result carries a nonzero value");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == StatOk || out_data.status == StatBadSym ||
                  out_data.status == StatNorm)
    else $error("undefined status code");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind symbol_matrix_chain_log_norm smcln_chk u_chk (.*);

// ===== tb/tb_top.sv =====
// Testbench for symbol_matrix_chain_log_norm: random and directed load and symbol
// beats, a bit-exact fixed-point predictor of the chain, and a result scoreboard.
// Depends on smcln_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
  import smcln_pkg::*;

  typedef longint unsigned u64_t;

  localparam longint CycleLimit = 4000000;
  localparam int     SettleCycles = 1500;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  smcln_in_t  in_data;
  smcln_out_t out_data;
  logic [4:0] cfg_data;

  symbol_matrix_chain_log_norm i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Predictor state of the chain.
  logic signed [31:0] mat_mem [StoreDep];
  logic signed [31:0] chain_vec [MaxDim];
  longint             ln_acc;
  logic [1:0]         err_code;
  logic [4:0]         size_reg;

  smcln_in_t  pending_items[$];
  smcln_out_t norm_results[$];
  int         errors = 0;
  int         results_seen = 0;
  int         symbols_seen = 0;
  longint     cycle_count = 0;
  bit         calm = 0;
  bit         took = 0;
  bit         cfg_done = 0;

  function automatic longint sat48(longint x);
    if (x > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (x < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return x;
  endfunction

  function automatic int bit_len(u64_t x);
    int b;
    b = 0;
    while (x != 0) begin
      b++;
      x >>= 1;
    end
    return b;
  endfunction

  function automatic longint log2_fix(u64_t x);
    int k;
    u64_t y;
    longint frac;
    k = bit_len(x) - 1;
    frac = 0;
    y = (k > 30) ? (x >> (k - 30)) : (x << (30 - k));
    for (int i = 0; i < 30; i++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (u64_t'(1) << 31)) begin
        frac |= 1;
        y >>= 1;
      end
    end
    return longint'(k) * (longint'(1) << 30) + frac;
  endfunction

  function automatic longint to_natural(longint l);
    u64_t mag, res;
    mag = (l < 0) ? u64_t'(-l) : u64_t'(l);
    res = (mag * 64'd46516320 + (u64_t'(1) << 31)) >> 32;
    return (l < 0) ? -longint'(res) : longint'(res);
  endfunction

  function automatic u64_t int_sqrt(u64_t s);
    u64_t res, b;
    res = 0;
    b = u64_t'(1) << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int dim_in_use();
    if (size_reg < 1) return 1;
    if (size_reg > MaxDim) return MaxDim;
    return size_reg;
  endfunction

  function automatic void restart_chain();
    for (int i = 0; i < MaxDim; i++) chain_vec[i] = 32'sh4000_0000;
    ln_acc = 0;
    err_code = StatOk;
  endfunction

  // One matrix-vector step with block normalization and ln(norm) accumulation.
  function automatic void chain_step(int sel, int n);
    longint p [MaxDim];
    longint acc, t;
    u64_t m, s, r, mag, v;
    int e;
    m = 0;
    s = 0;
    for (int rr = 0; rr < n; rr++) begin
      acc = 0;
      for (int cc = 0; cc < n; cc++) begin
        t = longint'(mat_mem[sel * 256 + rr * 16 + cc]) * longint'(chain_vec[cc]);
        if (t >= 0) acc += longint'(u64_t'(t) >> 16);
        else acc -= longint'(u64_t'(-t) >> 16);
      end
      p[rr] = acc;
      mag = (acc < 0) ? u64_t'(-acc) : u64_t'(acc);
      if (mag > m) m = mag;
    end
    if (m == 0) begin
      err_code = StatNorm;
      return;
    end
    e = bit_len(m) - 28;
    for (int rr = 0; rr < n; rr++) begin
      mag = (p[rr] < 0) ? u64_t'(-p[rr]) : u64_t'(p[rr]);
      mag = (e > 0) ? (mag >> e) : (mag << (-e));
      p[rr] = (p[rr] < 0) ? -longint'(mag) : longint'(mag);
      s += mag * mag;
    end
    r = int_sqrt(s);
    for (int rr = 0; rr < n; rr++) begin
      mag = (p[rr] < 0) ? u64_t'(-p[rr]) : u64_t'(p[rr]);
      v = (mag << 30) / r;
      chain_vec[rr] = (p[rr] < 0) ? -32'(v) : 32'(v);
    end
    ln_acc = sat48(ln_acc + to_natural(log2_fix(r) + longint'(e - 30) * (longint'(1) << 30)));
  endfunction

  function automatic void predict_beat(smcln_in_t it);
    int n;
    longint total, res;
    smcln_out_t o;
    n = dim_in_use();
    if (it.mode == 1'b0) begin
      mat_mem[it.matrix_index * 256 + it.row_index * 16 + it.col_index] = it.entry_value;
      return;
    end
    symbols_seen++;
    if (err_code == StatOk) begin
      if (it.symbol_char == CharZero || it.symbol_char == CharOne)
        chain_step(it.symbol_char == CharOne, n);
      else
        err_code = StatBadSym;
    end
    if (!it.last) return;
    res = 0;
    if (err_code == StatOk) begin
      total = 0;
      for (int i = 0; i < n; i++) total += chain_vec[i];
      if (total <= 0) err_code = StatNorm;
      else res = sat48(ln_acc + to_natural(log2_fix(u64_t'(total)) - 30 * (longint'(1) << 30)));
    end
    o.log_entrywise_norm = res[47:0];
    o.status = err_code;
    norm_results.push_back(o);
    restart_chain();
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 35);
  endfunction

  function automatic smcln_in_t raw_beat();
    return smcln_in_t'($bits(smcln_in_t)'({$urandom, $urandom}));
  endfunction

  // Driver: prediction happens at the accepting edge, new beats go out at the falling edge.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_valid && in_ready) begin
      predict_beat(in_data);
      took <= 1'b1;
    end
    if (cfg_valid && cfg_ready) begin
      size_reg <= cfg_data;
      restart_chain();
      cfg_done <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || took)) begin
      took <= 1'b0;
      if (pending_items.size() != 0 && !idle_now()) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && !idle_now();
  end

  // Monitor: compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      results_seen++;
      if (norm_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %h", out_data);
      end else begin
        smcln_out_t exp_beat;
        exp_beat = norm_results.pop_front();
        if (exp_beat !== out_data) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected log %0d status %0d, got log %0d status %0d",
                     exp_beat.log_entrywise_norm, exp_beat.status,
                     out_data.log_entrywise_norm, out_data.status);
        end
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic smcln_in_t load_beat(int sel, int row, int col, logic signed [31:0] val);
    smcln_in_t it;
    it = raw_beat();
    it.mode = 1'b0;
    it.matrix_index = 1'(sel);
    it.row_index = 4'(row);
    it.col_index = 4'(col);
    it.entry_value = val;
    return it;
  endfunction

  function automatic smcln_in_t sym_beat(logic [7:0] ch, bit fin);
    smcln_in_t it;
    it = raw_beat();
    it.mode = 1'b1;
    it.symbol_char = ch;
    it.last = fin;
    return it;
  endfunction

  function automatic logic signed [31:0] fair_entry();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return $urandom;
    if (pick < 25) return -$signed({1'b0, 31'($urandom_range(131072))});
    return $urandom_range(131072);
  endfunction

  // Mostly well-formed sequences: a few loads, then symbols closed by last.
  task automatic queue_traffic(int budget);
    int cnt, len;
    logic [7:0] ch;
    cnt = 0;
    while (cnt < budget) begin
      if ($urandom_range(99) < 8) begin
        pending_items.push_back(raw_beat());
        cnt++;
        continue;
      end
      repeat ($urandom_range(3)) begin
        pending_items.push_back(load_beat($urandom_range(1), $urandom_range(15),
                                          $urandom_range(15), fair_entry()));
        cnt++;
      end
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        ch = ($urandom_range(99) < 4) ? 8'($urandom) : 8'(CharZero + $urandom_range(1));
        pending_items.push_back(sym_beat(ch, i == len - 1));
        cnt++;
      end
    end
  endtask

  task automatic wait_quiet();
    while (pending_items.size() != 0 || in_valid || norm_results.size() != 0)
      @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_size(logic [4:0] v);
    wait_quiet();
    cfg_done = 0;
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    while (!cfg_done) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [4:0] sizes [9] = '{5'd0, 5'd31, 5'd2, 5'd3, 5'd5, 5'd8, 5'd1, 5'd4, 5'd16};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    size_reg = 5'd16;
    ln_acc = 0;
    err_code = StatOk;
    for (int i = 0; i < MaxDim; i++) chain_vec[i] = 32'sh4000_0000;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Fill both matrices completely so no symbol ever reads an unwritten entry.
    for (int s = 0; s < 2; s++)
      for (int r = 0; r < MaxDim; r++)
        for (int c = 0; c < MaxDim; c++)
          pending_items.push_back(load_beat(s, r, c, $urandom_range(131072)));

    // Directed part at full size: both symbols, bad bytes, extreme entries.
    pending_items.push_back(sym_beat(CharZero, 0));
    pending_items.push_back(sym_beat(CharOne, 1));
    pending_items.push_back(sym_beat(8'h78, 1));
    pending_items.push_back(sym_beat(CharOne, 0));
    pending_items.push_back(sym_beat(8'hFF, 0));
    pending_items.push_back(sym_beat(CharZero, 1));
    pending_items.push_back(sym_beat(8'h00, 1));
    pending_items.push_back(load_beat(1, 15, 15, 32'sh7FFF_FFFF));
    pending_items.push_back(load_beat(0, 0, 15, -32'sh8000_0000));
    pending_items.push_back(sym_beat(CharZero, 0));
    pending_items.push_back(sym_beat(CharOne, 1));

    // Size 1: zero norm, then a negative element sum, then a normal chain and a zero norm again.
    write_size(5'd1);
    pending_items.push_back(load_beat(0, 0, 0, 32'sd0));
    pending_items.push_back(sym_beat(CharZero, 1));
    pending_items.push_back(load_beat(1, 0, 0, -32'sd65536));
    pending_items.push_back(sym_beat(CharOne, 1));
    pending_items.push_back(load_beat(1, 0, 0, 32'sd196608));
    pending_items.push_back(sym_beat(CharOne, 0));
    pending_items.push_back(sym_beat(CharOne, 1));
    pending_items.push_back(sym_beat(CharZero, 1));

    foreach (sizes[k]) begin
      write_size(sizes[k]);
      calm = (k == 3);
      queue_traffic((sizes[k] == 5'd16 || sizes[k] == 5'd31) ? 40 : 85);
    end
    wait_quiet();
    calm = 0;

    $display("Covered %0d symbol beats and %0d result beats over sizes 0..31,",
             symbols_seen, results_seen);
    $display("including bad symbols, zero norms and nonpositive sums.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatching result beats", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== symbol_matrix_chain_log_norm.f =====
rtl/core/smcln_pkg.sv
rtl/core/smcln_ram.sv
rtl/core/smcln_ctrl.sv
rtl/core/smcln_dp.sv
rtl/core/symbol_matrix_chain_log_norm.sv
rtl/core/smcln_chk.sv
tb/tb_top.sv
